/* rtl/core/mbus_lfr_pkg.sv */
`timescale 1ns / 1ps

package mbus_lfr_pkg;

  // Frame delimiters and fixed header size
  localparam logic [7:0] StartByte      = 8'h68;
  localparam logic [7:0] StopByte       = 8'h16;
  localparam logic [7:0] HeaderSumBytes = 8'd3;

  // Register reset values
  localparam logic [7:0]  DefaultAddr = 8'd1;
  localparam logic [15:0] DefaultGap  = 16'd150;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // Configuration port
  localparam int unsigned AddrW = 3;
  localparam logic RegStation = 1'b0;
  localparam logic RegGap     = 1'b1;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindAccept = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone    = 3'd0,
    ErrStart   = 3'd1,
    ErrLength  = 3'd2,
    ErrStart2  = 3'd3,
    ErrAddress = 3'd4,
    ErrCsum    = 3'd5,
    ErrStop    = 3'd6,
    ErrTimeout = 3'd7
  } err_e;

  // Classified item as it travels through the queue
  typedef struct packed {
    logic       tick;
    logic [7:0] rx_byte;
    logic       is_start;
    logic       is_stop;
    logic       len_short;
  } entry_t;

  // Register values seen by the frame engine
  typedef struct packed {
    logic [7:0]  station_address;
    logic [15:0] gap_timeout_ticks;
  } cfg_t;

endpackage

/* rtl/core/mbus_lfr_if.sv */
`timescale 1ns / 1ps

// Input channel: one received byte or one tick per item
interface mbus_lfr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// Output channel: one user byte or one verdict per item
interface mbus_lfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [7:0] control_field;
  logic [7:0] ci_field;
  logic [2:0] error_code;

  modport source (output valid, output kind, output data_byte, output data_index,
                  output control_field, output ci_field, output error_code,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input data_index,
                  input control_field, input ci_field, input error_code,
                  output ready);
endinterface

/* rtl/core/mbus_long_frame_receiver.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// in_i      in   valid / ready    cmd, rx_byte
// out_o     out  valid / ready    kind, data_byte, data_index, control_field,
//                                 ci_field, error_code
// apb       in   psel / penable   paddr, pwdata -> prdata, pready (always high)
//
// One item per clock while the queue has room; an accepted item is first
// written to the queue, then the frame engine loads its result into the output register.
// The frame engine steps one queue entry per cycle while the output register
// is free or being taken; ready drops only when the queue is full.
// Reset is asynchronous: parser state and queue clear, registers return to
// station address 1 and gap timeout 150 ticks. No clearing pass.
module mbus_long_frame_receiver #(
  parameter int unsigned QueueDepth = mbus_lfr_pkg::QueueDepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mbus_lfr_in_if.sink                      in_i,
  mbus_lfr_out_if.source                   out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbus_lfr_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mbus_lfr_pkg::*;

  logic [7:0]  station_q;
  logic [15:0] gap_q;
  cfg_t        cfg;
  logic        reg_sel;
  logic        cfg_wr;

  logic        push;
  logic        can_push;
  entry_t      push_entry;
  logic        pop;
  logic        head_valid;
  entry_t      head;

  // Register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[AddrW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= DefaultAddr;
      gap_q     <= DefaultGap;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegStation: station_q <= pwdata[7:0];
        default:    gap_q     <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      RegStation: prdata = {24'd0, station_q};
      default:    prdata = {16'd0, gap_q};
    endcase
  end

  assign cfg.station_address   = station_q;
  assign cfg.gap_timeout_ticks = gap_q;

  mbus_lfr_front u_front (
    .in_i       (in_i),
    .can_push_i (can_push),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  mbus_lfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (push_entry),
    .can_push_o   (can_push),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mbus_lfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

/* rtl/core/mbus_lfr_front.sv */
`timescale 1ns / 1ps

module mbus_lfr_front (
  mbus_lfr_in_if.sink           in_i,
  input  logic                  can_push_i,
  output logic                  push_o,
  output mbus_lfr_pkg::entry_t  entry_o
);
  import mbus_lfr_pkg::*;

  // Take an item whenever the queue has room
  assign in_i.ready = can_push_i;
  assign push_o     = in_i.valid && can_push_i;

  // Classify the byte ahead of the frame engine
  always_comb begin
    entry_o.tick      = in_i.cmd;
    entry_o.rx_byte   = in_i.rx_byte;
    entry_o.is_start  = (in_i.rx_byte == StartByte);
    entry_o.is_stop   = (in_i.rx_byte == StopByte);
    entry_o.len_short = (in_i.rx_byte < HeaderSumBytes);
  end

endmodule

/* rtl/core/mbus_lfr_queue.sv */
`timescale 1ns / 1ps

module mbus_lfr_queue #(
  parameter int unsigned Depth = mbus_lfr_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mbus_lfr_pkg::entry_t  entry_i,
  output logic                  can_push_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output mbus_lfr_pkg::entry_t  head_o
);
  import mbus_lfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign can_push_o   = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/core/mbus_lfr_back.sv */
`timescale 1ns / 1ps

module mbus_lfr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mbus_lfr_pkg::cfg_t    cfg_i,
  input  logic                  head_valid_i,
  input  mbus_lfr_pkg::entry_t  head_i,
  output logic                  pop_o,
  mbus_lfr_out_if.source        out_o
);
  import mbus_lfr_pkg::*;

  // Frame phases
  localparam logic [3:0] PhHunt   = 4'd0;
  localparam logic [3:0] PhLen1   = 4'd1;
  localparam logic [3:0] PhLen2   = 4'd2;
  localparam logic [3:0] PhStart2 = 4'd3;
  localparam logic [3:0] PhCtrl   = 4'd4;
  localparam logic [3:0] PhAddr   = 4'd5;
  localparam logic [3:0] PhCi     = 4'd6;
  localparam logic [3:0] PhData   = 4'd7;
  localparam logic [3:0] PhCsum   = 4'd8;
  localparam logic [3:0] PhStop   = 4'd9;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  held_ctrl_q, held_ctrl_d;
  logic [7:0]  held_ci_q, held_ci_d;
  logic [15:0] gap_q, gap_d;

  logic        out_valid_q, out_valid_d;
  kind_e       kind_q;
  logic [7:0]  data_byte_q, data_index_q, ctrl_field_q, ci_field_q;
  err_e        err_q;

  logic        hunting;
  logic        verdict;
  logic        res_valid;
  kind_e       res_kind;
  logic [7:0]  res_data, res_index;
  err_e        res_err;
  logic [7:0]  count_inc;
  logic        data_done;
  logic [7:0]  b;

  // Take the next item once the output register is free or draining
  assign pop_o = head_valid_i && (!out_valid_q || out_o.ready);

  assign b         = head_i.rx_byte;
  assign hunting   = !(phase_q inside {[PhLen1:PhStop]});
  assign count_inc = count_q + 8'd1;
  assign data_done = ({1'b0, count_inc} + {1'b0, HeaderSumBytes}) >= {1'b0, frame_len_q};

  // Step the frame parser by one item
  always_comb begin
    phase_d     = phase_q;
    frame_len_d = frame_len_q;
    count_d     = count_q;
    sum_d       = sum_q;
    held_ctrl_d = held_ctrl_q;
    held_ci_d   = held_ci_q;
    gap_d       = gap_q;
    verdict     = 1'b0;
    res_valid   = 1'b0;
    res_kind    = KindData;
    res_data    = '0;
    res_index   = '0;
    res_err     = ErrNone;

    if (pop_o) begin
      if (head_i.tick) begin
        if (!hunting) begin
          if (gap_q >= cfg_i.gap_timeout_ticks) begin
            verdict = 1'b1;
            res_err = ErrTimeout;
          end else begin
            gap_d = gap_q + 16'd1;
          end
        end
      end else begin
        gap_d = '0;
        case (phase_q)
          PhLen1: begin
            if (head_i.len_short) begin
              verdict = 1'b1;
              res_err = ErrLength;
            end else begin
              frame_len_d = b;
              phase_d     = PhLen2;
            end
          end
          PhLen2: begin
            if (b != frame_len_q) begin
              verdict = 1'b1;
              res_err = ErrLength;
            end else begin
              phase_d = PhStart2;
            end
          end
          PhStart2: begin
            if (!head_i.is_start) begin
              verdict = 1'b1;
              res_err = ErrStart2;
            end else begin
              phase_d = PhCtrl;
            end
          end
          PhCtrl: begin
            held_ctrl_d = b;
            sum_d       = b;
            phase_d     = PhAddr;
          end
          PhAddr: begin
            if (b != cfg_i.station_address) begin
              verdict = 1'b1;
              res_err = ErrAddress;
            end else begin
              sum_d   = sum_q + b;
              phase_d = PhCi;
            end
          end
          PhCi: begin
            held_ci_d = b;
            sum_d     = sum_q + b;
            count_d   = '0;
            phase_d   = (frame_len_q == HeaderSumBytes) ? PhCsum : PhData;
          end
          PhData: begin
            res_valid = 1'b1;
            res_kind  = KindData;
            res_data  = b;
            res_index = count_q;
            sum_d     = sum_q + b;
            count_d   = count_inc;
            if (data_done) begin
              phase_d = PhCsum;
            end
          end
          PhCsum: begin
            if (b != sum_q) begin
              verdict = 1'b1;
              res_err = ErrCsum;
            end else begin
              phase_d = PhStop;
            end
          end
          PhStop: begin
            verdict = 1'b1;
            res_err = head_i.is_stop ? ErrNone : ErrStop;
          end
          default: begin
            // hunting, also out of an unused phase code
            if (!head_i.is_start) begin
              verdict = 1'b1;
              res_err = ErrStart;
            end else begin
              held_ctrl_d = '0;
              held_ci_d   = '0;
              phase_d     = PhLen1;
            end
          end
        endcase
      end

      // Any verdict ends the frame
      if (verdict) begin
        res_valid   = 1'b1;
        res_kind    = (res_err == ErrNone) ? KindAccept : KindReject;
        phase_d     = PhHunt;
        frame_len_d = '0;
        count_d     = '0;
        sum_d       = '0;
        gap_d       = '0;
      end
    end
  end

  // Load the output register on a result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      frame_len_q <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      held_ctrl_q <= '0;
      held_ci_q   <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      frame_len_q <= frame_len_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      held_ctrl_q <= held_ctrl_d;
      held_ci_q   <= held_ci_d;
      gap_q       <= gap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      kind_q       <= res_kind;
      data_byte_q  <= res_data;
      data_index_q <= res_index;
      ctrl_field_q <= verdict ? held_ctrl_q : 8'd0;
      ci_field_q   <= verdict ? held_ci_q : 8'd0;
      err_q        <= res_err;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = kind_q;
  assign out_o.data_byte     = data_byte_q;
  assign out_o.data_index    = data_index_q;
  assign out_o.control_field = ctrl_field_q;
  assign out_o.ci_field      = ci_field_q;
  assign out_o.error_code    = err_q;

endmodule

/* rtl/core/mbus_lfr_checker.sv */
`timescale 1ns / 1ps

module mbus_lfr_sva (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_kind,
  input logic [7:0]                      out_data_byte,
  input logic [7:0]                      out_data_index,
  input logic [7:0]                      out_control_field,
  input logic [7:0]                      out_ci_field,
  input logic [2:0]                      out_error_code,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [mbus_lfr_pkg::AddrW-1:0]  paddr,
  input logic [31:0]                     pwdata,
  input logic [31:0]                     prdata,
  input logic                            pready
);
  import mbus_lfr_pkg::*;

  logic        out_acc;
  logic        cfg_wr;
  logic [31:0] wr_expect;
  logic [36:0] out_payload;
  logic        last_data_q;
  logic [7:0]  last_index_q;

  assign out_acc     = out_valid && out_ready;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign wr_expect   = (paddr[AddrW-1] == RegStation) ? {24'd0, pwdata[7:0]}
                                                      : {16'd0, pwdata[15:0]};
  assign out_payload = {out_kind, out_data_byte, out_data_index,
                        out_control_field, out_ci_field, out_error_code};

  // Track the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_data_q  <= 1'b0;
      last_index_q <= '0;
    end else if (out_acc) begin
      last_data_q  <= (out_kind == KindData);
      last_index_q <= out_data_index;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // User bytes of a frame are delivered with consecutive indexes
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_kind == KindData) && (out_data_index != 8'd0) |->
      last_data_q && ((last_index_q + 8'd1) == out_data_index))
    else $error("user byte index out of sequence");

  // A written register reads back
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr ##1 (paddr == $past(paddr)) |-> prdata == $past(wr_expect))
    else $error("register readback mismatch");

  // An open output keeps the input open on the next cycle
  a_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_ready) |-> in_ready)
    else $error("input stalled although output was draining");

endmodule

bind mbus_long_frame_receiver mbus_lfr_sva u_mbus_lfr_sva (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready          (in_i.ready),
  .out_valid         (out_o.valid),
  .out_ready         (out_o.ready),
  .out_kind          (out_o.kind),
  .out_data_byte     (out_o.data_byte),
  .out_data_index    (out_o.data_index),
  .out_control_field (out_o.control_field),
  .out_ci_field      (out_o.ci_field),
  .out_error_code    (out_o.error_code),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .paddr             (paddr),
  .pwdata            (pwdata),
  .prdata            (prdata),
  .pready            (pready)
);

/* tb/sv/mbus_lfr_checker.sv */
`timescale 1ns / 1ps

module mbus_lfr_checker
  import mbus_lfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  mbus_lfr_in_if           in_i,
  mbus_lfr_out_if          out_i,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  input  logic [31:0]      prdata,
  input  logic             pready,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef enum logic [3:0] {
    StHunt, StLen1, StLen2, StStart2, StCtrl, StAddr, StCi, StData, StCsum, StStop
  } parse_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [7:0] control_field;
    logic [7:0] ci_field;
    err_e       error_code;
  } frame_result_t;

  // Shadow of the parser and of its registers
  parse_state_e  state;
  logic [7:0]    len_q;
  logic [7:0]    count_q;
  logic [7:0]    sum_q;
  logic [7:0]    ctrl_q;
  logic [7:0]    ci_q;
  logic [15:0]   gap_q;
  logic [7:0]    addr_cfg;
  logic [15:0]   gap_cfg;

  frame_result_t expected_q[$];
  int unsigned   errors = 0;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Emit the verdict and drop back to hunting
  function automatic frame_result_t close_frame(input err_e code);
    frame_result_t r;
    r = '0;
    r.kind = (code == ErrNone) ? KindAccept : KindReject;
    r.control_field = ctrl_q;
    r.ci_field = ci_q;
    r.error_code = code;
    state = StHunt;
    len_q = '0;
    count_q = '0;
    sum_q = '0;
    gap_q = '0;
    return r;
  endfunction

  // Advance the frame parser by one item; returns 1 when a result is due
  function automatic bit advance_frame(input logic tick, input logic [7:0] b,
                                       output frame_result_t r);
    r = '0;
    if (tick) begin
      if (state == StHunt) return 1'b0;
      if (gap_q >= gap_cfg) begin
        r = close_frame(ErrTimeout);
        return 1'b1;
      end
      gap_q = gap_q + 16'd1;
      return 1'b0;
    end
    gap_q = '0;
    case (state)
      StHunt: begin
        if (b != StartByte) begin
          r = close_frame(ErrStart);
          return 1'b1;
        end
        ctrl_q = '0;
        ci_q = '0;
        state = StLen1;
      end
      StLen1: begin
        if (b < HeaderSumBytes) begin
          r = close_frame(ErrLength);
          return 1'b1;
        end
        len_q = b;
        state = StLen2;
      end
      StLen2: begin
        if (b != len_q) begin
          r = close_frame(ErrLength);
          return 1'b1;
        end
        state = StStart2;
      end
      StStart2: begin
        if (b != StartByte) begin
          r = close_frame(ErrStart2);
          return 1'b1;
        end
        state = StCtrl;
      end
      StCtrl: begin
        ctrl_q = b;
        sum_q = b;
        state = StAddr;
      end
      StAddr: begin
        if (b != addr_cfg) begin
          r = close_frame(ErrAddress);
          return 1'b1;
        end
        sum_q = sum_q + b;
        state = StCi;
      end
      StCi: begin
        ci_q = b;
        sum_q = sum_q + b;
        count_q = '0;
        state = (len_q == HeaderSumBytes) ? StCsum : StData;
      end
      StData: begin
        r.kind = KindData;
        r.data_byte = b;
        r.data_index = count_q;
        sum_q = sum_q + b;
        count_q = count_q + 8'd1;
        if ({1'b0, count_q} + {1'b0, HeaderSumBytes} >= {1'b0, len_q}) state = StCsum;
        return 1'b1;
      end
      StCsum: begin
        if (b != sum_q) begin
          r = close_frame(ErrCsum);
          return 1'b1;
        end
        state = StStop;
      end
      default: begin
        r = close_frame((b != StopByte) ? ErrStop : ErrNone);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Track register accesses, predict on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    frame_result_t fresh;
    if (!rst_ni) begin
      state <= StHunt;
      len_q <= '0;
      count_q <= '0;
      sum_q <= '0;
      ctrl_q <= '0;
      ci_q <= '0;
      gap_q <= '0;
      addr_cfg <= DefaultAddr;
      gap_cfg <= DefaultGap;
      expected_q.delete();
      pending_o <= 0;
      fail_count_o <= errors;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[AddrW-1:2] == RegStation) addr_cfg = pwdata[7:0];
          else gap_cfg = pwdata[15:0];
        end else if (paddr[AddrW-1:2] == RegStation) begin
          check_field("prdata station_address", {24'b0, addr_cfg}, prdata);
        end else begin
          check_field("prdata gap_timeout_ticks", {16'b0, gap_cfg}, prdata);
        end
      end

      if (out_i.valid && out_i.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: kind %0d", out_i.kind);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", want.kind, out_i.kind);
          check_field("data_byte", want.data_byte, out_i.data_byte);
          check_field("data_index", want.data_index, out_i.data_index);
          check_field("control_field", want.control_field, out_i.control_field);
          check_field("ci_field", want.ci_field, out_i.ci_field);
          check_field("error_code", want.error_code, out_i.error_code);
        end
      end

      if (in_i.valid && in_i.ready) begin
        if (advance_frame(in_i.cmd, in_i.rx_byte, fresh)) expected_q.push_back(fresh);
      end

      pending_o <= expected_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import mbus_lfr_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 70;
  localparam logic [AddrW-1:0] StationOffset = {RegStation, 2'b00};
  localparam logic [AddrW-1:0] GapOffset     = {RegGap, 2'b00};

  typedef enum {
    FaultNone, FaultStart, FaultShort, FaultLenMismatch, FaultStart2,
    FaultAddr, FaultCsum, FaultStop, FaultTimeout, FaultCut
  } fault_e;

  typedef enum {StallNone, StallHalf, StallHeavy, StallLight} stall_e;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int unsigned      fail_count;
  int unsigned      pending;

  mbus_lfr_in_if  in_ch ();
  mbus_lfr_out_if out_ch ();

  mbus_long_frame_receiver u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mbus_lfr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  int unsigned burst_left = 0;
  int unsigned sent = 0;
  logic [7:0]  cur_addr = DefaultAddr;
  logic [15:0] cur_gap = DefaultGap;
  bit          hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort when nothing moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stall stretches, plus one long hold-off on request
  initial begin
    stall_e      mode;
    int unsigned stretch;
    out_ch.ready = 1'b0;
    mode = StallNone;
    stretch = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode = stall_e'($urandom_range(0, 3));
          stretch = $urandom_range(8, 64);
        end
        stretch--;
        case (mode)
          StallNone:  out_ch.ready <= 1'b1;
          StallHalf:  out_ch.ready <= 1'($urandom_range(0, 1));
          StallHeavy: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one item, in bursts separated by random gaps
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int unsigned gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_len > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop offering and let every expected result drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] a,
                            input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Write both registers while idle, then read them back
  task automatic configure(input logic [7:0] addr, input logic [15:0] gap);
    settle();
    apb_access(1'b1, StationOffset, {24'b0, addr});
    apb_access(1'b1, GapOffset, {16'b0, gap});
    apb_access(1'b0, StationOffset, '0);
    apb_access(1'b0, GapOffset, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    cur_addr = addr;
    cur_gap = gap;
  endtask

  function automatic logic [7:0] flip_some(input logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  // Build one frame, optionally break it, and send it with ticks between bytes
  task automatic send_frame(input int unsigned forced_len, input bit clean);
    logic [7:0]  frame[$];
    logic [7:0]  len;
    logic [7:0]  sum;
    fault_e      fault;
    int unsigned cut;
    int unsigned pick;
    int unsigned ticks;
    if (forced_len != 0) len = 8'(forced_len);
    else if ($urandom_range(0, 99) < 3) len = 8'($urandom_range(100, 255));
    else len = 8'($urandom_range(3, 24));
    frame = {StartByte, len, len, StartByte, 8'($urandom), cur_addr, 8'($urandom)};
    sum = frame[4] + frame[5] + frame[6];
    for (int i = 0; i < int'(len) - 3; i++) begin
      frame.push_back(8'($urandom));
      sum = sum + frame[$];
    end
    frame.push_back(sum);
    frame.push_back(StopByte);

    pick = $urandom_range(0, 20);
    fault = (clean || pick < 12) ? FaultNone : fault_e'(pick - 11);
    if (fault == FaultTimeout && cur_gap > 20) fault = FaultNone;
    cut = frame.size();
    case (fault)
      FaultStart: begin
        frame[0] = flip_some(StartByte);
        cut = 1;
      end
      FaultShort: begin
        frame[1] = 8'($urandom_range(0, 2));
        cut = 2;
      end
      FaultLenMismatch: begin
        frame[2] = flip_some(frame[1]);
        cut = 3;
      end
      FaultStart2: begin
        frame[3] = flip_some(StartByte);
        cut = 4;
      end
      FaultAddr: begin
        frame[5] = flip_some(cur_addr);
        cut = 6;
      end
      FaultCsum: begin
        frame[frame.size() - 2] = flip_some(sum);
        cut = frame.size() - 1;
      end
      FaultStop:                  frame[frame.size() - 1] = flip_some(StopByte);
      FaultTimeout, FaultCut:     cut = $urandom_range(1, frame.size() - 1);
      default: ;
    endcase

    for (int unsigned i = 0; i < cut; i++) begin
      if (i > 0 && cur_gap > 0 && $urandom_range(0, 9) == 0) begin
        ticks = $urandom_range(1, (cur_gap < 3) ? cur_gap : 3);
        repeat (ticks) begin
          send_item(1'b1, 8'($urandom));
          sent++;
        end
      end
      send_item(1'b0, frame[i]);
      sent++;
    end
    if (fault == FaultTimeout) begin
      repeat (int'(cur_gap) + 1) begin
        send_item(1'b1, 8'($urandom));
        sent++;
      end
    end
  endtask

  // Mostly well-formed frames, with idle ticks and stray bytes between them
  task automatic run_random();
    logic [7:0] noise;
    sent = 0;
    while (sent < PhaseItems) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) send_item(1'b1, 8'($urandom));
        1: begin
          noise = 8'($urandom);
          if (noise == StartByte) noise = ~noise;
          send_item(1'b0, noise);
          sent++;
        end
        default: send_frame(0, 1'b0);
      endcase
    end
  endtask

  initial begin
    logic [7:0] directed_bytes[];
    directed_bytes = '{
      8'h00, 8'hFF,
      StartByte, 8'h02,
      StartByte, 8'h05, 8'h06,
      StartByte, 8'h03, 8'h03, 8'h67,
      StartByte, 8'h03, 8'h03, StartByte, 8'hFF, DefaultAddr, 8'h00, 8'h00, StopByte
    };
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.rx_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values read back, then the directed cases
    apb_access(1'b0, StationOffset, '0);
    apb_access(1'b0, GapOffset, '0);
    psel <= 1'b0;
    penable <= 1'b0;
    send_item(1'b1, 8'hFF);
    foreach (directed_bytes[i]) send_item(1'b0, directed_bytes[i]);
    run_random();

    configure(8'h00, 16'd1);
    run_random();

    // Widest settings; long hold-off while a maximum-length frame streams in
    configure(8'hFF, 16'hFFFF);
    hold_req = 1'b1;
    send_frame(255, 1'b1);
    run_random();

    configure(8'($urandom), 16'd0);
    run_random();

    configure(8'hA5, 16'd3);
    run_random();

    configure(8'($urandom), 16'($urandom_range(2, 20)));
    run_random();

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
